// ===== rtl/core/double_ended_queue_top_defines.svh =====
`ifndef DOUBLE_ENDED_QUEUE_TOP_DEFINES_SVH
`define DOUBLE_ENDED_QUEUE_TOP_DEFINES_SVH

// same-cycle implication, checked out of reset
`define DEQ_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked out of reset
`define DEQ_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/deq_pkg.sv =====
package deq_pkg;

	localparam int DEPTH        = 16;
	localparam int HANDLE_WIDTH = 16;

	localparam int FIELD_W = 16;
	localparam int CMD_W   = 3;
	localparam int STORE_W = (HANDLE_WIDTH < FIELD_W) ? HANDLE_WIDTH : FIELD_W;
	localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W   = $clog2(DEPTH + 1);
	localparam int SUM_W   = CNT_W + 1;

	typedef enum logic [CMD_W-1:0] {
		CMD_PUSH_FRONT = 3'd0,
		CMD_PUSH_BACK  = 3'd1,
		CMD_POP_FRONT  = 3'd2,
		CMD_POP_BACK   = 3'd3,
		CMD_PEEK_FRONT = 3'd4,
		CMD_PEEK_BACK  = 3'd5,
		CMD_CLEAR      = 3'd6
	} cmd_t;

	typedef struct packed {
		logic load;
		logic exec;
	} ctl_t;

	// ring position base + off, with base < DEPTH and off <= DEPTH
	function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] base,
			input logic [CNT_W-1:0] off);
		logic [SUM_W-1:0] s;
		s = SUM_W'(base) + SUM_W'(off);
		if (s >= SUM_W'(DEPTH)) begin
			s = s - SUM_W'(DEPTH);
		end
		return s[IDX_W-1:0];
	endfunction

endpackage

// ===== rtl/core/double_ended_queue_top.sv =====
// double-ended queue of item handles held in a ring of DEPTH entries
//
// command channel: drive cmd and item_handle with start high; the command
// transfers at the rising edge where start is high and busy is low
// cmd codes: push front, push back, pop front, pop back, peek front,
// peek back, clear; code seven does nothing but report the flags
//
// result channel: done is high for exactly one cycle per command, in the
// response state after execute, with out_handle, out_valid, is_empty,
// is_full and overflow; the receiver has no way to stall the result
//
// execution: busy is high for the execute cycle, in which the ring indexes
// update and the handle ram is read or written once; a new command may
// transfer in the cycle that shows a result, but never while busy is high
//
// reset: the queue comes up empty with the front index at zero; handle ram
// contents are not cleared, and only pushed entries can ever be read
module double_ended_queue_top (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [deq_pkg::CMD_W-1:0]    cmd,
	input  logic [deq_pkg::FIELD_W-1:0]  item_handle,
	output logic                         done,
	output logic [deq_pkg::FIELD_W-1:0]  out_handle,
	output logic                         out_valid,
	output logic                         is_empty,
	output logic                         is_full,
	output logic                         overflow
);
	import deq_pkg::*;

	ctl_t ctl;

	deq_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.ctl    (ctl)
	);

	deq_dpath u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (ctl),
		.cmd         (cmd),
		.item_handle (item_handle),
		.out_handle  (out_handle),
		.out_valid   (out_valid),
		.is_empty    (is_empty),
		.is_full     (is_full),
		.overflow    (overflow)
	);

endmodule

// ===== rtl/core/deq_ctrl.sv =====
`include "double_ended_queue_top_defines.svh"

module deq_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	output logic          done,
	output deq_pkg::ctl_t ctl
);
	import deq_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_RESP
	} state_t;

	state_t state_q;
	logic   busy_q;
	logic   done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE, ST_RESP: begin
					done_q <= 1'b0;
					if (start) begin
						state_q <= ST_EXEC;
						busy_q  <= 1'b1;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_EXEC: begin
					state_q <= ST_RESP;
					busy_q  <= 1'b0;
					done_q  <= 1'b1;
				end
				default: begin
					state_q <= ST_IDLE;
					busy_q  <= 1'b0;
					done_q  <= 1'b0;
				end
			endcase
		end
	end

	assign busy     = busy_q;
	assign done     = done_q;
	assign ctl.load = start & ~busy_q;
	assign ctl.exec = busy_q;

	`DEQ_ASSERT_NXT(a_accept_busy, start && !busy, busy, "accepted command did not raise busy")
	`DEQ_ASSERT_NXT(a_exec_done, busy, done && !busy, "no result strobe after execute")
	`DEQ_ASSERT_IMP(a_done_free, done, !busy, "result strobe while busy")

endmodule

// ===== rtl/core/deq_dpath.sv =====
`include "double_ended_queue_top_defines.svh"

module deq_dpath (
	input  logic                         clk,
	input  logic                         arst_n,
	input  deq_pkg::ctl_t                ctl,
	input  logic [deq_pkg::CMD_W-1:0]    cmd,
	input  logic [deq_pkg::FIELD_W-1:0]  item_handle,
	output logic [deq_pkg::FIELD_W-1:0]  out_handle,
	output logic                         out_valid,
	output logic                         is_empty,
	output logic                         is_full,
	output logic                         overflow
);
	import deq_pkg::*;

	logic [STORE_W-1:0] mem [DEPTH];

	cmd_t               cmd_q;
	logic [STORE_W-1:0] handle_q;
	logic [IDX_W-1:0]   front_q;
	logic [CNT_W-1:0]   count_q;
	logic [STORE_W-1:0] rd_q;
	logic               valid_q;
	logic               ovf_q;
	logic               empty_q;
	logic               full_q;

	logic               cur_full;
	logic               cur_empty;
	logic [IDX_W-1:0]   front_dec;
	logic [IDX_W-1:0]   front_nxt;
	logic [CNT_W-1:0]   count_nxt;
	logic [IDX_W-1:0]   wr_addr;
	logic [IDX_W-1:0]   rd_addr;
	logic               wr_en;
	logic               rd_en;
	logic               ovf_nxt;

	assign cur_full  = (count_q == CNT_W'(DEPTH));
	assign cur_empty = (count_q == '0);
	assign front_dec = (front_q == '0) ? IDX_W'(DEPTH - 1) : front_q - 1'b1;

	always_comb begin
		front_nxt = front_q;
		count_nxt = count_q;
		wr_addr   = front_dec;
		rd_addr   = front_q;
		wr_en     = 1'b0;
		rd_en     = 1'b0;
		ovf_nxt   = 1'b0;
		case (cmd_q) inside
			CMD_PUSH_FRONT: begin
				if (cur_full) begin
					ovf_nxt = 1'b1;
				end else begin
					wr_en     = 1'b1;
					wr_addr   = front_dec;
					front_nxt = front_dec;
					count_nxt = count_q + 1'b1;
				end
			end
			CMD_PUSH_BACK: begin
				if (cur_full) begin
					ovf_nxt = 1'b1;
				end else begin
					wr_en     = 1'b1;
					wr_addr   = ring_add(front_q, count_q);
					count_nxt = count_q + 1'b1;
				end
			end
			CMD_POP_FRONT, CMD_PEEK_FRONT: begin
				rd_addr = front_q;
				rd_en   = ~cur_empty;
				if (cmd_q == CMD_POP_FRONT && !cur_empty) begin
					front_nxt = ring_add(front_q, CNT_W'(1));
					count_nxt = count_q - 1'b1;
				end
			end
			CMD_POP_BACK, CMD_PEEK_BACK: begin
				rd_addr = ring_add(front_q, count_q - 1'b1);
				rd_en   = ~cur_empty;
				if (cmd_q == CMD_POP_BACK && !cur_empty) begin
					count_nxt = count_q - 1'b1;
				end
			end
			CMD_CLEAR: begin
				front_nxt = '0;
				count_nxt = '0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q    <= cmd_t'(cmd);
			handle_q <= item_handle[STORE_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.exec && wr_en) begin
			mem[wr_addr] <= handle_q;
		end
		if (ctl.exec && rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= '0;
			count_q <= '0;
			valid_q <= 1'b0;
			ovf_q   <= 1'b0;
			empty_q <= 1'b1;
			full_q  <= 1'b0;
		end else if (ctl.exec) begin
			front_q <= front_nxt;
			count_q <= count_nxt;
			valid_q <= rd_en;
			ovf_q   <= ovf_nxt;
			empty_q <= (count_nxt == '0);
			full_q  <= (count_nxt == CNT_W'(DEPTH));
		end
	end

	assign out_handle = valid_q ? FIELD_W'(rd_q) : '0;
	assign out_valid  = valid_q;
	assign is_empty   = empty_q;
	assign is_full    = full_q;
	assign overflow   = ovf_q;

	`DEQ_ASSERT_IMP(a_count_range, 1'b1, count_q <= CNT_W'(DEPTH), "entry count beyond depth")
	`DEQ_ASSERT_IMP(a_front_range, 1'b1, front_q < IDX_W'(DEPTH) || DEPTH == (1 << IDX_W), "front index beyond ring")
	`DEQ_ASSERT_NXT(a_refused_hold, ctl.exec && ovf_nxt, $stable(count_q) && $stable(front_q), "refused push changed the ring")
	`DEQ_ASSERT_IMP(a_no_rw, ctl.exec, !(wr_en && rd_en), "read and write in one command")

endmodule
